// ===== rtl/lse_pkg.sv =====
// lse_pkg: shared types, constants and the spi bit encoding function for the
// led strip effect encoder. Depends on nothing; used by every file in rtl.
package lse_pkg;

    // field widths
    localparam int CHAN_W       = 8;
    localparam int LED_NUM_W    = 6;
    localparam int ENC_W        = 64;
    localparam int LED_COUNT_DEF = 16;

    // spi byte patterns for one colour bit
    localparam logic [7:0] ONE_PATTERN  = 8'hFC;
    localparam logic [7:0] ZERO_PATTERN = 8'hC0;

    // serial scale unit geometry
    localparam int MUL_A_W   = 9;
    localparam int MUL_B_W   = 8;
    localparam int NUM_W     = 17;
    localparam int DIV_W     = 10;
    localparam int STEP_CNT_W = 5;

    // scale constants for each effect: q = (a * b + bias) / divisor
    localparam logic [8:0] FADE_BIAS   = 9'd2;
    localparam logic [9:0] FADE_DIV    = 10'd5;
    localparam logic [8:0] BREATH_BIAS = 9'd255;
    localparam logic [9:0] BREATH_DIV  = 10'd510;
    localparam logic [8:0] RAMP_BIAS   = 9'd5;
    localparam logic [9:0] RAMP_DIV    = 10'd10;

    // ramp geometry and chase pacing
    localparam logic [2:0] RAMP_LAST  = 3'd5;
    localparam logic [2:0] CHASE_WAIT = 3'd6;

    // effect modes
    localparam logic [1:0] MODE_FADE   = 2'd0;
    localparam logic [1:0] MODE_BREATH = 2'd1;
    localparam logic [1:0] MODE_RAMP   = 2'd2;

    // configuration register indexes
    localparam logic CFG_EFFECT_MODE  = 1'b0;
    localparam logic CFG_COLOUR_ORDER = 1'b1;

    // operands for one serial scale lane
    typedef struct packed {
        logic [MUL_A_W-1:0] mult_a;
        logic [MUL_B_W-1:0] mult_b;
        logic [8:0]         bias;
        logic [DIV_W-1:0]   divisor;
    } scale_op_t;

    // one colour bit becomes one spi byte, msb first
    function automatic logic [ENC_W-1:0] encode_channel(input logic [CHAN_W-1:0] v);
        logic [ENC_W-1:0] acc;
        acc = '0;
        for (int b = CHAN_W - 1; b >= 0; b--) begin
            acc = {acc[ENC_W-9:0], (v[b] ? ONE_PATTERN : ZERO_PATTERN)};
        end
        return acc;
    endfunction

endpackage

// ===== rtl/lse_scale_lane.sv =====
// lse_scale_lane: bit-serial scale unit, q = (a * b + bias) / divisor.
// Shift-add multiply one multiplier bit per cycle, then restoring divide one
// quotient bit per cycle. Depends on lse_pkg.
module lse_scale_lane (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  lse_pkg::scale_op_t op,
    output logic               done,
    output logic [7:0]         quotient
);
    import lse_pkg::*;

    typedef enum logic [1:0] {
        LN_IDLE,
        LN_MUL,
        LN_DIV
    } lane_state_t;

    lane_state_t           state_reg, state_next;
    logic [NUM_W-1:0]      acc_reg, acc_next;
    logic [NUM_W-1:0]      a_sh_reg, a_sh_next;
    logic [MUL_B_W-1:0]    b_sh_reg, b_sh_next;
    logic [DIV_W-1:0]      div_reg, div_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [DIV_W:0]        trial;
    logic                  trial_ge;

    // one restoring division step
    assign trial    = {rem_reg, acc_reg[NUM_W-1]};
    assign trial_ge = trial >= {1'b0, div_reg};

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        a_sh_next  = a_sh_reg;
        b_sh_next  = b_sh_reg;
        div_next   = div_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            LN_IDLE: begin
                if (start) begin
                    acc_next   = NUM_W'(op.bias);
                    a_sh_next  = NUM_W'(op.mult_a);
                    b_sh_next  = op.mult_b;
                    div_next   = op.divisor;
                    cnt_next   = '0;
                    state_next = LN_MUL;
                end
            end
            // shift-add, one multiplier bit per cycle
            LN_MUL: begin
                if (b_sh_reg[0]) begin
                    acc_next = acc_reg + a_sh_reg;
                end
                a_sh_next = {a_sh_reg[NUM_W-2:0], 1'b0};
                b_sh_next = {1'b0, b_sh_reg[MUL_B_W-1:1]};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(MUL_B_W - 1)) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = LN_DIV;
                end
            end
            // quotient bits shift into the low end of the numerator
            LN_DIV: begin
                rem_next = trial_ge ? DIV_W'(trial - {1'b0, div_reg}) : trial[DIV_W-1:0];
                acc_next = {acc_reg[NUM_W-2:0], trial_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(NUM_W - 1)) begin
                    done_next  = 1'b1;
                    state_next = LN_IDLE;
                end
            end
            default: begin
                state_next = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LN_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
        acc_reg  <= acc_next;
        a_sh_reg <= a_sh_next;
        b_sh_reg <= b_sh_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg[7:0];

    // a start is only issued to an idle lane
    assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> state_reg == LN_IDLE)
        else $error("lane started while busy");

    // the remainder stays below the divisor through the whole division
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == LN_DIV |-> rem_reg < div_reg)
        else $error("lane remainder out of range");

    // done follows the last division step
    assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> $past(state_reg) == LN_DIV)
        else $error("lane done without division");

endmodule

// ===== rtl/lse_led_store.sv =====
// lse_led_store: per-led colour memory with one write and one registered read
// port; valid bits cleared by reset make unwritten entries read as black.
// Depends on lse_pkg.
module lse_led_store #(
    parameter int LED_COUNT = lse_pkg::LED_COUNT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         wr_en,
    input  logic [$clog2(LED_COUNT)-1:0] wr_addr,
    input  logic [3*lse_pkg::CHAN_W-1:0] wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(LED_COUNT)-1:0] rd_addr,
    output logic [3*lse_pkg::CHAN_W-1:0] rd_data
);
    import lse_pkg::*;

    localparam int COL_W = 3 * CHAN_W;

    logic [COL_W-1:0]     mem [LED_COUNT];
    logic [LED_COUNT-1:0] valid_reg;
    logic [COL_W-1:0]     rd_word_reg;
    logic                 rd_valid_reg;

    // memory array: write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // valid bits, one per entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_word_reg : '0;

endmodule

// ===== rtl/led_strip_effect_encoder_unit.sv =====
// led_strip_effect_encoder_unit: per tick, updates the effect state and emits
// one word per led. A serial scale pass runs start, multiply, divide and done;
// fade and breath need one pass, a ramp move six. The words follow the scaling,
// or the tick itself when no scaling is needed; each led word is read from the
// led store and then loaded into the output register once that is free.
// Reset is synchronous, active low: state clears and the led store reads black.
module led_strip_effect_encoder_unit #(
    parameter int LED_COUNT = lse_pkg::LED_COUNT_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [1:0]   cfg_wdata,
    // input words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // target_red, target_green, target_blue
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata,   // led_number, first_channel_bytes,
                                    // second_channel_bytes, third_channel_bytes
    output logic         m_tlast    // frame_end
);
    import lse_pkg::*;

    localparam int IDX_W = $clog2(LED_COUNT);
    localparam int COL_W = 3 * CHAN_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_CALC,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef enum logic [1:0] {
        KIND_FADE,
        KIND_BREATH,
        KIND_RAMP
    } kind_t;

    state_t               state_reg, state_next;
    kind_t                kind_reg, kind_next;
    logic [1:0]           mode_reg, mode_next;
    logic                 order_reg, order_next;
    logic [COL_W-1:0]     tgt_reg, tgt_next;
    logic [COL_W-1:0]     cur_reg, cur_next;
    logic [7:0]           level_reg, level_next;
    logic                 rising_reg, rising_next;
    logic [2:0]           delay_reg, delay_next;
    logic [6:0]           head_reg, head_next;
    logic [2:0]           ramp_i_reg, ramp_i_next;
    logic                 fill_reg, fill_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [LED_NUM_W-1:0] num_reg, num_next;
    logic [CHAN_W-1:0]    first_reg, first_next;
    logic [CHAN_W-1:0]    second_reg, second_next;
    logic [CHAN_W-1:0]    third_reg, third_next;
    logic                 last_reg, last_next;

    scale_op_t            lane_op [3];
    logic [2:0]           lane_done;
    logic [7:0]           lane_q [3];
    logic                 lane_start;
    logic                 calc_done;

    logic                 accept;
    logic                 lit;
    logic                 out_free;
    logic [7:0]           level_step;
    logic [7:0]           pos_sum;
    logic [IDX_W-1:0]     ramp_pos;
    logic [COL_W-1:0]     lane_word;
    logic [COL_W-1:0]     emit_col;

    logic                 st_wr_en;
    logic [IDX_W-1:0]     st_wr_addr;
    logic [COL_W-1:0]     st_wr_data;
    logic                 st_rd_en;
    logic [COL_W-1:0]     st_rd_data;

    assign accept     = s_tvalid && s_tready;
    assign lit        = s_tdata != '0;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign lane_start = state_reg == ST_START;
    assign calc_done  = &lane_done;
    assign lane_word  = {lane_q[2], lane_q[1], lane_q[0]};

    // breath level one step on from the stored level
    always_comb begin
        level_step = level_reg;
        if (rising_reg) begin
            if (level_reg != 8'hFF) begin
                level_step = level_reg + 8'd1;
            end
        end else begin
            if (level_reg != 8'h00) begin
                level_step = level_reg - 8'd1;
            end
        end
    end

    // ramp position of the current step, wrapped once around the strip
    always_comb begin
        pos_sum = 8'(head_reg) - 8'd1 + 8'(ramp_i_reg);
        if (pos_sum >= 8'(LED_COUNT)) begin
            pos_sum = pos_sum - 8'(LED_COUNT);
        end
        ramp_pos = pos_sum[IDX_W-1:0];
    end

    // operands for the three channel lanes
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (kind_reg)
                KIND_FADE: begin
                    lane_op[c].mult_a  = (cur_reg[8*c +: 8] > tgt_reg[8*c +: 8]) ?
                        MUL_A_W'(cur_reg[8*c +: 8] - tgt_reg[8*c +: 8]) :
                        MUL_A_W'(tgt_reg[8*c +: 8] - cur_reg[8*c +: 8]);
                    lane_op[c].mult_b  = 8'd1;
                    lane_op[c].bias    = FADE_BIAS;
                    lane_op[c].divisor = FADE_DIV;
                end
                KIND_BREATH: begin
                    lane_op[c].mult_a  = {tgt_reg[8*c +: 8], 1'b0};
                    lane_op[c].mult_b  = level_reg;
                    lane_op[c].bias    = BREATH_BIAS;
                    lane_op[c].divisor = BREATH_DIV;
                end
                default: begin
                    lane_op[c].mult_a  = {tgt_reg[8*c +: 8], 1'b0};
                    lane_op[c].mult_b  = 8'(ramp_i_reg);
                    lane_op[c].bias    = RAMP_BIAS;
                    lane_op[c].divisor = RAMP_DIV;
                end
            endcase
        end
    end

    // serial scale lanes, one per colour channel
    for (genvar g = 0; g < 3; g++) begin : g_lane
        lse_scale_lane u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (lane_start),
            .op       (lane_op[g]),
            .done     (lane_done[g]),
            .quotient (lane_q[g])
        );
    end

    lse_led_store #(
        .LED_COUNT (LED_COUNT)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (idx_reg),
        .rd_data (st_rd_data)
    );

    // colour of the led being emitted
    assign emit_col = fill_reg ? cur_reg : st_rd_data;

    // store access
    always_comb begin
        st_rd_en   = state_reg == ST_EMIT_RD;
        st_wr_en   = 1'b0;
        st_wr_addr = idx_reg;
        st_wr_data = cur_reg;
        if (state_reg == ST_CALC && kind_reg == KIND_RAMP && calc_done) begin
            st_wr_en   = 1'b1;
            st_wr_addr = ramp_pos;
            st_wr_data = lane_word;
        end else if (state_reg == ST_EMIT_LD && out_free && fill_reg) begin
            st_wr_en = 1'b1;
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        mode_next     = mode_reg;
        order_next    = order_reg;
        tgt_next      = tgt_reg;
        cur_next      = cur_reg;
        level_next    = level_reg;
        rising_next   = rising_reg;
        delay_next    = delay_reg;
        head_next     = head_reg;
        ramp_i_next   = ramp_i_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        num_next      = num_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        third_next    = third_reg;
        last_next     = last_reg;

        // configuration writes
        if (cfg_wr_en) begin
            case (cfg_index)
                CFG_EFFECT_MODE:  mode_next  = cfg_wdata;
                CFG_COLOUR_ORDER: order_next = cfg_wdata[0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    tgt_next   = s_tdata;
                    fill_next  = 1'b0;
                    idx_next   = '0;
                    state_next = ST_EMIT_RD;
                    case (mode_reg)
                        MODE_FADE: begin
                            if (s_tdata != cur_reg) begin
                                kind_next  = KIND_FADE;
                                state_next = ST_START;
                            end
                        end
                        MODE_BREATH: begin
                            if (lit) begin
                                level_next = level_step;
                                if (level_step == 8'hFF) begin
                                    rising_next = 1'b0;
                                end else if (level_step == 8'h00) begin
                                    rising_next = 1'b1;
                                end
                                kind_next  = KIND_BREATH;
                                state_next = ST_START;
                            end
                        end
                        MODE_RAMP: begin
                            if (lit) begin
                                if (delay_reg >= CHASE_WAIT) begin
                                    delay_next  = '0;
                                    head_next   = (head_reg >= 7'(LED_COUNT)) ?
                                                  7'd1 : head_reg + 7'd1;
                                    ramp_i_next = '0;
                                    kind_next   = KIND_RAMP;
                                    state_next  = ST_START;
                                end else begin
                                    delay_next = delay_reg + 3'd1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_START: begin
                state_next = ST_CALC;
            end
            ST_CALC: begin
                if (calc_done) begin
                    case (kind_reg)
                        KIND_FADE: begin
                            for (int c = 0; c < 3; c++) begin
                                cur_next[8*c +: 8] =
                                    (cur_reg[8*c +: 8] > tgt_reg[8*c +: 8]) ?
                                    cur_reg[8*c +: 8] - lane_q[c] :
                                    cur_reg[8*c +: 8] + lane_q[c];
                            end
                            fill_next  = 1'b1;
                            state_next = ST_EMIT_RD;
                        end
                        KIND_BREATH: begin
                            cur_next   = lane_word;
                            fill_next  = 1'b1;
                            state_next = ST_EMIT_RD;
                        end
                        default: begin
                            if (ramp_i_reg == RAMP_LAST) begin
                                state_next = ST_EMIT_RD;
                            end else begin
                                ramp_i_next = ramp_i_reg + 3'd1;
                                state_next  = ST_START;
                            end
                        end
                    endcase
                end
            end
            ST_EMIT_RD: begin
                state_next = ST_EMIT_LD;
            end
            // load one led word once the output register is free
            ST_EMIT_LD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    num_next      = LED_NUM_W'(idx_reg);
                    first_next    = order_reg ? emit_col[15:8] : emit_col[7:0];
                    second_next   = order_reg ? emit_col[7:0] : emit_col[15:8];
                    third_next    = emit_col[23:16];
                    last_next     = idx_reg == IDX_W'(LED_COUNT - 1);
                    if (idx_reg == IDX_W'(LED_COUNT - 1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            kind_reg     <= KIND_FADE;
            mode_reg     <= MODE_FADE;
            order_reg    <= 1'b0;
            cur_reg      <= '0;
            level_reg    <= '0;
            rising_reg   <= 1'b1;
            delay_reg    <= '0;
            head_reg     <= '0;
            ramp_i_reg   <= '0;
            fill_reg     <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            kind_reg     <= kind_next;
            mode_reg     <= mode_next;
            order_reg    <= order_next;
            cur_reg      <= cur_next;
            level_reg    <= level_next;
            rising_reg   <= rising_next;
            delay_reg    <= delay_next;
            head_reg     <= head_next;
            ramp_i_reg   <= ramp_i_next;
            fill_reg     <= fill_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        tgt_reg    <= tgt_next;
        num_reg    <= num_next;
        first_reg  <= first_next;
        second_reg <= second_next;
        third_reg  <= third_next;
        last_reg   <= last_next;
    end

    // output word
    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {2'b00, encode_channel(third_reg), encode_channel(second_reg),
                       encode_channel(first_reg), num_reg};

    // the frame ends on the last led of the strip
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> num_reg == LED_NUM_W'(LED_COUNT - 1))
        else $error("frame end on wrong led");

    // a pending word is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT_LD && m_tvalid_reg && !m_tready |=> $stable(num_reg))
        else $error("pending word overwritten");

    // breath state moves only on an accepted tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(level_reg) && $stable(rising_reg))
        else $error("breath state changed without a tick");

    // the chase head never passes the strip length
    assert property (@(posedge aclk) disable iff (!aresetn)
        head_reg <= 7'(LED_COUNT) && ramp_i_reg <= RAMP_LAST)
        else $error("ramp position out of range");

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for led_strip_effect_encoder_unit; a queue fed
// driver, a stalling monitor and a cycle-free predictor of fade, breath and ramp.
// Depends on rtl/lse_pkg.sv and rtl/led_strip_effect_encoder_unit.sv.
`timescale 1ns / 1ps

module testbench;
    import lse_pkg::*;

    localparam int NUM_LEDS = LED_COUNT_DEF;
    localparam logic [1:0] MODE_IDLE = 2'd3;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    typedef struct packed {
        logic [LED_NUM_W-1:0] led;
        logic [ENC_W-1:0]     first;
        logic [ENC_W-1:0]     second;
        logic [ENC_W-1:0]     third;
        logic                 last;
    } frame_word_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_index = 1'b0;
    logic [1:0]   cfg_wdata = 2'd0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata = 24'd0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [199:0] m_tdata;
    logic         m_tlast;

    led_strip_effect_encoder_unit #(.LED_COUNT(NUM_LEDS)) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // effect state mirror and register copies
    logic [1:0]  fx_mode = MODE_FADE;
    logic        grb_order = 1'b0;
    pixel_t      glow = '0;
    pixel_t      strip_model [NUM_LEDS];
    logic [7:0]  breath_lvl = 8'd0;
    logic        breath_up = 1'b1;
    logic [2:0]  chase_wait = 3'd0;
    logic [6:0]  chase_pos = 7'd0;

    logic [23:0] pending_ticks [$];
    frame_word_t frame_words_due [$];

    int ticks_queued = 0;
    int ticks_accepted = 0;
    int words_checked = 0;
    int error_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_cycle = 0;

    // one colour bit per spi byte, msb in the top byte
    function automatic logic [ENC_W-1:0] spi_bytes(input logic [7:0] v);
        logic [ENC_W-1:0] acc;
        acc = '0;
        for (int b = 0; b < 8; b++)
            acc[b*8 +: 8] = v[b] ? ONE_PATTERN : ZERO_PATTERN;
        return acc;
    endfunction

    // move one channel by its distance / 5, rounded
    function automatic logic [7:0] fade_step(input logic [7:0] cur, input logic [7:0] tgt);
        int d;
        if (cur > tgt) begin
            d = int'(cur) - int'(tgt);
            return cur - 8'((d + int'(FADE_BIAS)) / int'(FADE_DIV));
        end
        if (cur < tgt) begin
            d = int'(tgt) - int'(cur);
            return cur + 8'((d + int'(FADE_BIAS)) / int'(FADE_DIV));
        end
        return cur;
    endfunction

    function automatic logic [7:0] breath_scale(input logic [7:0] t, input logic [7:0] k);
        return 8'((2 * int'(t) * int'(k) + int'(BREATH_BIAS)) / int'(BREATH_DIV));
    endfunction

    function automatic logic [7:0] ramp_scale(input logic [7:0] t, input int i);
        return 8'((2 * int'(t) * i + int'(RAMP_BIAS)) / int'(RAMP_DIV));
    endfunction

    // apply one tick to the mirror state and queue the frame it produces
    task automatic predict_frame(input logic [23:0] word);
        pixel_t      goal;
        logic        lit;
        int          spot;
        frame_word_t fw;
        goal.r = word[7:0];
        goal.g = word[15:8];
        goal.b = word[23:16];
        lit = (goal != '0);
        case (fx_mode)
            MODE_FADE: begin
                if (goal != glow) begin
                    glow.r = fade_step(glow.r, goal.r);
                    glow.g = fade_step(glow.g, goal.g);
                    glow.b = fade_step(glow.b, goal.b);
                    for (int k = 0; k < NUM_LEDS; k++) strip_model[k] = glow;
                end
            end
            MODE_BREATH: begin
                if (lit) begin
                    if (breath_up) begin
                        if (breath_lvl != 8'd255) breath_lvl = breath_lvl + 8'd1;
                    end else if (breath_lvl != 8'd0) begin
                        breath_lvl = breath_lvl - 8'd1;
                    end
                    glow.r = breath_scale(goal.r, breath_lvl);
                    glow.g = breath_scale(goal.g, breath_lvl);
                    glow.b = breath_scale(goal.b, breath_lvl);
                    if (breath_lvl == 8'd255) breath_up = 1'b0;
                    else if (breath_lvl == 8'd0) breath_up = 1'b1;
                    for (int k = 0; k < NUM_LEDS; k++) strip_model[k] = glow;
                end
            end
            MODE_RAMP: begin
                if (lit) begin
                    if (chase_wait >= CHASE_WAIT) begin
                        chase_wait = 3'd0;
                        if (int'(chase_pos) >= NUM_LEDS) chase_pos = 7'd1;
                        else chase_pos = chase_pos + 7'd1;
                        for (int k = 0; k <= int'(RAMP_LAST); k++) begin
                            spot = (int'(chase_pos) - 1 + k) % NUM_LEDS;
                            strip_model[spot].r = ramp_scale(goal.r, k);
                            strip_model[spot].g = ramp_scale(goal.g, k);
                            strip_model[spot].b = ramp_scale(goal.b, k);
                        end
                    end else begin
                        chase_wait = chase_wait + 3'd1;
                    end
                end
            end
            default: ;
        endcase
        for (int k = 0; k < NUM_LEDS; k++) begin
            fw.led    = LED_NUM_W'(k);
            fw.first  = spi_bytes(grb_order ? strip_model[k].g : strip_model[k].r);
            fw.second = spi_bytes(grb_order ? strip_model[k].r : strip_model[k].g);
            fw.third  = spi_bytes(strip_model[k].b);
            fw.last   = (k == NUM_LEDS - 1);
            frame_words_due.push_back(fw);
        end
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_frame(s_tdata);
                ticks_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_ticks.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                                 : $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR: %s", msg);
    endtask

    // receiver: checks each accepted word and stalls on a rotating pattern
    always @(posedge aclk) begin : rx_side
        frame_word_t got;
        frame_word_t want;
        logic        rdy;
        if (aresetn && m_tvalid && m_tready) begin
            got.led    = m_tdata[5:0];
            got.first  = m_tdata[69:6];
            got.second = m_tdata[133:70];
            got.third  = m_tdata[197:134];
            got.last   = m_tlast;
            words_checked++;
            if (frame_words_due.size() == 0) begin
                log_error($sformatf("unexpected word led=%0d last=%0b", got.led, got.last));
            end else begin
                want = frame_words_due.pop_front();
                if (got.led !== want.led || got.first !== want.first ||
                    got.second !== want.second || got.third !== want.third ||
                    got.last !== want.last)
                    log_error($sformatf(
                        "word %0d: exp led=%0d %h %h %h last=%0b got led=%0d %h %h %h last=%0b",
                        words_checked, want.led, want.first, want.second, want.third,
                        want.last, got.led, got.first, got.second, got.third, got.last));
            end
        end
        rx_cycle++;
        case ((rx_cycle >> 9) & 3)
            0: rdy = 1'b1;
            1: rdy = ($urandom_range(0, 9) < 6);
            2: rdy = ((rx_cycle & 3) == 0);
            default: rdy = ((rx_cycle % 7) != 3) && ($urandom_range(0, 3) != 0);
        endcase
        m_tready <= rdy;
    end

    // register write, mirrored at once since the block is idle
    task automatic write_reg(input logic idx, input logic [1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_EFFECT_MODE) fx_mode = val;
        else grb_order = val[0];
    endtask

    task automatic queue_tick(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pending_ticks.push_back({b, g, r});
        ticks_queued++;
    endtask

    // every queued tick taken and every frame word seen
    task automatic wait_drained();
        while (ticks_accepted != ticks_queued) @(posedge aclk);
        while (frame_words_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input logic [1:0] mode, input logic ord);
        wait_drained();
        write_reg(CFG_EFFECT_MODE, mode);
        write_reg(CFG_COLOUR_ORDER, {1'($urandom_range(0, 1)), ord});
    endtask

    // channel values lean toward the extremes
    function automatic logic [7:0] pick_channel();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic random_phase(input logic [1:0] mode, input int n_ticks, input int black_pct);
        int         sent;
        int         hold;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        configure(mode, 1'($urandom_range(0, 1)));
        sent = 0;
        while (sent < n_ticks) begin
            if ($urandom_range(0, 99) < black_pct) begin
                r = 8'd0; g = 8'd0; b = 8'd0;
            end else begin
                r = pick_channel(); g = pick_channel(); b = pick_channel();
            end
            hold = (mode == MODE_FADE) ? $urandom_range(1, 12) : $urandom_range(1, 3);
            repeat (hold) begin
                queue_tick(r, g, b);
                sent++;
            end
            // target equal to the current colour leaves everything alone
            if (mode == MODE_FADE && $urandom_range(0, 3) == 0) begin
                wait_drained();
                queue_tick(glow.r, glow.g, glow.b);
                sent++;
            end
        end
    endtask

    // main sequence
    initial begin
        for (int k = 0; k < NUM_LEDS; k++) strip_model[k] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // fade: sub-step distances, equal target, extremes
        write_reg(CFG_EFFECT_MODE, MODE_FADE);
        write_reg(CFG_COLOUR_ORDER, 2'b00);
        queue_tick(8'd1, 8'd2, 8'd0);
        queue_tick(8'd0, 8'd0, 8'd0);
        queue_tick(8'd255, 8'd255, 8'd255);
        queue_tick(8'd255, 8'd255, 8'd255);
        queue_tick(8'd0, 8'd255, 8'd0);
        queue_tick(8'd255, 8'd0, 8'd255);
        queue_tick(8'h80, 8'h01, 8'hFE);

        // green-first order, with the unused upper data bit set
        configure(MODE_FADE, 1'b1);
        write_reg(CFG_COLOUR_ORDER, 2'b11);
        queue_tick(8'd255, 8'd0, 8'd0);

        // breath: lit, black hold, lit again
        configure(MODE_BREATH, 1'b0);
        queue_tick(8'd255, 8'd255, 8'd255);
        queue_tick(8'd0, 8'd0, 8'd0);
        queue_tick(8'd255, 8'd128, 8'd1);

        // ramp: seven lit ticks move it once, black holds
        configure(MODE_RAMP, 1'b0);
        repeat (7) queue_tick(8'd255, 8'd255, 8'd255);
        queue_tick(8'd0, 8'd0, 8'd0);

        // mode without effect
        configure(MODE_IDLE, 1'b1);
        queue_tick(8'd10, 8'd20, 8'd30);

        // random phases; the long breath run reaches full level and turns back
        random_phase(MODE_FADE, 30, 10);
        random_phase(MODE_BREATH, 280, 5);
        random_phase(MODE_RAMP, 50, 10);
        random_phase(MODE_IDLE, 8, 20);
        random_phase(MODE_FADE, 15, 10);

        wait_drained();
        repeat (60) @(posedge aclk);
        $display("covered %0d ticks and %0d led words over fade, breath, ramp and idle modes",
                 ticks_accepted, words_checked);
        $display("in both channel orders; %0d mismatches, %0d words still due",
                 error_count, frame_words_due.size());
        if (error_count == 0 && frame_words_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("timeout: %0d of %0d ticks taken, %0d words due",
                 ticks_accepted, ticks_queued, frame_words_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
